/* design/sst_pkg.sv */
package sst_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned FillW      = $clog2(StackDepth + 1);
  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 7;
  localparam int unsigned OpW        = 2;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [FillW-1:0]        fill_t;
  typedef logic [CountW-1:0]       count_t;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SORT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_KEY_RD,
    ST_KEY_WAIT,
    ST_CMP,
    ST_INS,
    ST_FIN_RD,
    ST_FIN_WAIT
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic   valid;
    word_t  value;
    count_t count;
    logic   fault;
  } res_t;

endpackage

/* design/sst_if.sv */
interface sst_in_if;
  import sst_pkg::*;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic signed [WordW-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sst_out_if;
  import sst_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [WordW-1:0] result_value;
  logic [CountW-1:0] item_count;
  logic              fault;

  modport source (output valid, output result_value, output item_count, output fault,
                  input ready);
  modport sink   (input valid, input result_value, input item_count, input fault,
                  output ready);
endinterface

/* design/sortable_stack.sv */
// Bounded stack of signed 32-bit words (depth sst_pkg::StackDepth) with push, pop and
// sort commands, one result item per command item. Push writes the store directly; pop
// waits in ST_POP_WAIT for the registered read of the word store. Sort is an insertion
// sort run by a small sequencer around one signed comparator and the single-read,
// single-write store, leaving the smallest word on top. The block takes no new item
// while a command is in progress, and a result left waiting in the output register
// holds off the next command until it is taken. Push on a full stack and pop on an
// empty one set fault and change nothing; item_count carries the low 7 bits of the
// fill level.
module sortable_stack (
  input  logic          clk_i,
  input  logic          rst_ni,
  sst_in_if.sink        in_i,
  sst_out_if.source     out_o
);
  import sst_pkg::*;

  mem_req_t mem_req;
  word_t    rd_data;
  res_t     res;
  logic     out_free;

  logic     out_valid_q;
  word_t    out_value_q;
  count_t   out_count_q;
  logic     out_fault_q;

  assign out_free = !out_valid_q || out_o.ready;

  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.opcode),
    .in_value_i (in_i.value),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .rd_data_i  (rd_data),
    .mem_req_o  (mem_req),
    .res_o      (res)
  );

  sst_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_value_q <= res.value;
      out_count_q <= res.count;
      out_fault_q <= res.fault;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.item_count   = out_count_q;
  assign out_o.fault        = out_fault_q;

  a_res_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result produced while output register busy");

  a_accept_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> out_free)
    else $error("item taken while output register busy");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fault_q) |->
      (out_count_q == '0 || out_count_q == count_t'(StackDepth)))
    else $error("fault with a count that is neither empty nor full");

endmodule

/* design/sst_store.sv */
module sst_store (
  input  logic              clk_i,
  input  sst_pkg::mem_req_t req_i,
  output sst_pkg::word_t    rd_data_o
);
  import sst_pkg::*;

  word_t mem_q [StackDepth];
  word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_q;

endmodule

/* design/sst_ctrl.sv */
module sst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [sst_pkg::OpW-1:0] in_op_i,
  input  sst_pkg::word_t    in_value_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  sst_pkg::word_t    rd_data_i,
  output sst_pkg::mem_req_t mem_req_o,
  output sst_pkg::res_t     res_o
);
  import sst_pkg::*;

  state_e state_q, state_d;
  fill_t  fill_q, fill_d;
  fill_t  i_q, i_d;
  addr_t  j_q, j_d;
  word_t  key_q, key_d;

  logic   accept;
  logic   less;
  fill_t  i_next;
  fill_t  fill_dec;

  assign in_ready_o = (state_q == ST_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  // single signed compare unit, used by the sort
  assign less       = rd_data_i < key_q;
  assign i_next     = i_q + fill_t'(1);
  assign fill_dec   = fill_q - fill_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    key_q <= key_d;
  end

  always_comb begin
    state_d         = state_q;
    fill_d          = fill_q;
    i_d             = i_q;
    j_d             = j_q;
    key_d           = key_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = fill_q[AddrW-1:0];
    mem_req_o.wdata = in_value_i;
    mem_req_o.raddr = fill_dec[AddrW-1:0];
    res_o.valid     = 1'b0;
    res_o.value     = '0;
    res_o.count     = count_t'(fill_q);
    res_o.fault     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_PUSH: begin
              res_o.valid = 1'b1;
              res_o.value = in_value_i;
              if (fill_q == fill_t'(StackDepth)) begin
                res_o.fault = 1'b1;
              end else begin
                mem_req_o.we = 1'b1;
                fill_d       = fill_q + fill_t'(1);
                res_o.count  = count_t'(fill_d);
              end
            end
            OP_POP: begin
              if (fill_q == '0) begin
                res_o.valid = 1'b1;
                res_o.fault = 1'b1;
              end else begin
                fill_d  = fill_dec;
                state_d = ST_POP_WAIT;
              end
            end
            OP_SORT: begin
              if (fill_q == '0) begin
                res_o.valid = 1'b1;
              end else begin
                i_d     = fill_t'(1);
                state_d = (fill_t'(1) < fill_q) ? ST_KEY_RD : ST_FIN_RD;
              end
            end
            default: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end
      ST_POP_WAIT: begin
        mem_req_o.raddr = fill_q[AddrW-1:0];
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.value = rd_data_i;
          state_d     = ST_IDLE;
        end
      end
      ST_KEY_RD: begin
        mem_req_o.raddr = i_q[AddrW-1:0];
        state_d         = ST_KEY_WAIT;
      end
      ST_KEY_WAIT: begin
        key_d           = rd_data_i;
        j_d             = i_q[AddrW-1:0];
        mem_req_o.raddr = i_q[AddrW-1:0] - addr_t'(1);
        state_d         = ST_CMP;
      end
      ST_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        if (less) begin
          // shift the smaller word up one place
          mem_req_o.wdata = rd_data_i;
          j_d             = j_q - addr_t'(1);
          mem_req_o.raddr = j_q - addr_t'(2);
          if (j_q == addr_t'(1)) begin
            state_d = ST_INS;
          end
        end else begin
          mem_req_o.wdata = key_q;
          i_d             = i_next;
          state_d         = (i_next < fill_q) ? ST_KEY_RD : ST_FIN_RD;
        end
      end
      ST_INS: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = key_q;
        i_d             = i_next;
        state_d         = (i_next < fill_q) ? ST_KEY_RD : ST_FIN_RD;
      end
      ST_FIN_RD: begin
        state_d = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.value = rd_data_i;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sim/sortable_stack_tb.sv */
module sortable_stack_tb;
  import sst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandPerPhase = 310;
  localparam int unsigned NumRows = 19;

  typedef struct packed {
    word_t  value;
    count_t count;
    logic   fault;
  } stack_res_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    word_t          val;
    logic           typed;
    word_t          exp_value;
    count_t         exp_count;
    logic           exp_fault;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sst_in_if  in_if ();
  sst_out_if out_if ();

  sortable_stack u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  word_t       held_words [StackDepth];
  int unsigned held_count;
  stack_res_t  pending_q [$];
  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  cmd_row_t    cmd_rows [NumRows];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // insertion sort, smallest word ends on top
  function automatic void sort_held_words();
    word_t       key;
    int unsigned j;
    for (int unsigned i = 1; i < held_count; i++) begin
      key = held_words[i];
      j = i;
      while (j > 0 && held_words[j-1] < key) begin
        held_words[j] = held_words[j-1];
        j--;
      end
      held_words[j] = key;
    end
  endfunction

  function automatic stack_res_t step_stack(input logic [OpW-1:0] op, input word_t val);
    stack_res_t r;
    r = '0;
    case (op)
      OP_PUSH: begin
        r.value = val;
        if (held_count >= StackDepth) begin
          r.fault = 1'b1;
        end else begin
          held_words[held_count] = val;
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == 0) begin
          r.fault = 1'b1;
        end else begin
          held_count--;
          r.value = held_words[held_count];
        end
      end
      OP_SORT: begin
        if (held_count > 0) begin
          sort_held_words();
          r.value = held_words[held_count-1];
        end
      end
      default: ;
    endcase
    r.count = count_t'(held_count);
    return r;
  endfunction

  function automatic word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return word_t'($signed($urandom_range(0, 7)) - 4);
      default: return word_t'($urandom);
    endcase
  endfunction

  // mode 0 grows the stack, mode 1 shrinks it, mode 2 keeps it level
  function automatic logic [OpW-1:0] rand_op(input int unsigned mode);
    int unsigned pick;
    int unsigned push_pct;
    pick = $urandom_range(0, 99);
    push_pct = (mode == 0) ? 65 : (mode == 1) ? 26 : 46;
    if (pick < push_pct) return OP_PUSH;
    if (pick < 92) return OP_POP;
    if (pick < 96) return OP_SORT;
    return OpUnused;
  endfunction

  task automatic send_item(input logic [OpW-1:0] op, input word_t val,
                           input logic typed, input stack_res_t typed_res);
    stack_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.value  <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = step_stack(op, val);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // result side: random back-pressure and field checks
  initial begin
    stack_res_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %h count %0d fault %b", $time,
                   out_if.result_value, out_if.item_count, out_if.fault);
        end else begin
          want = pending_q.pop_front();
          if (out_if.result_value !== want.value) begin
            errors++;
            $display("%0t: result_value expected %h actual %h", $time,
                     want.value, out_if.result_value);
          end
          if (out_if.item_count !== want.count) begin
            errors++;
            $display("%0t: item_count expected %0d actual %0d", $time,
                     want.count, out_if.item_count);
          end
          if (out_if.fault !== want.fault) begin
            errors++;
            $display("%0t: fault expected %b actual %b", $time, want.fault, out_if.fault);
          end
        end
      end
      out_if.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int unsigned mode;
    stack_res_t  tr;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_PUSH;
    in_if.value  <= '0;
    errors = 0;
    cycle_cnt = 0;
    held_count = 0;
    send_idle_pct = 38;
    recv_idle_pct = 61;

    cmd_rows[0]  = '{OP_POP,   32'sd0,            1'b1, 32'sd0,            7'd0, 1'b1};
    cmd_rows[1]  = '{OP_SORT,  32'sd0,            1'b1, 32'sd0,            7'd0, 1'b0};
    cmd_rows[2]  = '{OpUnused, 32'sh1234_5678,    1'b1, 32'sd0,            7'd0, 1'b0};
    cmd_rows[3]  = '{OP_PUSH,  32'sh7FFF_FFFF,    1'b1, 32'sh7FFF_FFFF,    7'd1, 1'b0};
    cmd_rows[4]  = '{OP_PUSH,  32'sh8000_0000,    1'b1, 32'sh8000_0000,    7'd2, 1'b0};
    cmd_rows[5]  = '{OP_PUSH,  32'sd0,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[6]  = '{OP_PUSH,  -32'sd1,           1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[7]  = '{OP_PUSH,  32'sd1,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[8]  = '{OP_SORT,  32'sh5555_AAAA,    1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[9]  = '{OP_POP,   32'shFFFF_FFFF,    1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[10] = '{OP_POP,   32'sd0,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[11] = '{OpUnused, 32'shAAAA_5555,    1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[12] = '{OP_POP,   32'sd0,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[13] = '{OP_POP,   32'sd0,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[14] = '{OP_POP,   32'sd0,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[15] = '{OP_POP,   32'sd0,            1'b1, 32'sd0,            7'd0, 1'b1};
    cmd_rows[16] = '{OP_PUSH,  32'sd5,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[17] = '{OP_SORT,  32'sd0,            1'b0, 32'sd0,            7'd0, 1'b0};
    cmd_rows[18] = '{OP_POP,   32'sd0,            1'b0, 32'sd0,            7'd0, 1'b0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned k = 0; k < NumRows; k++) begin
      tr = '{cmd_rows[k].exp_value, cmd_rows[k].exp_count, cmd_rows[k].exp_fault};
      send_item(cmd_rows[k].op, cmd_rows[k].val, cmd_rows[k].typed, tr);
    end

    for (int unsigned phase = 0; phase < 3; phase++) begin
      wait_results_drained();
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 38 : 0;
      if (phase == 0) begin
        // overfill, sort a full stack, then pop past empty
        for (int unsigned k = 0; k < StackDepth + 2; k++) begin
          send_item(OP_PUSH, rand_word(), 1'b0, '0);
        end
        send_item(OP_SORT, rand_word(), 1'b0, '0);
        for (int unsigned k = 0; k < StackDepth + 2; k++) begin
          send_item(OP_POP, rand_word(), 1'b0, '0);
        end
      end
      mode = 0;
      for (int unsigned k = 0; k < RandPerPhase; k++) begin
        if (k % 40 == 0) mode = $urandom_range(0, 2);
        send_item(rand_op(mode), rand_word(), 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
